### hdl/mbpm_pkg.sv
`timescale 1ns / 1ps

package mbpm_pkg;

  // Default table and window depth.
  localparam int MAX_PATTERN_DEF = 64;

  // Fixed field widths.
  localparam int ENTRY_W = 6;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Mismatch bits are reduced in groups of this size in the first reduction stage.
  localparam int GRP_W = 16;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Register indexes.
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_IGNORE_CASE    = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic             ignore_case;
  } cfg_t;

  // One classified request waiting between the front and the back.
  typedef struct packed {
    logic               is_byte;
    logic [ENTRY_W-1:0] entry;
    logic [BYTE_W-1:0]  data;
    logic               care;
    logic               last;
  } item_t;

  // Folds A-Z to a-z when case folding is enabled.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic icase);
    if (icase && (c >= 8'h41) && (c <= 8'h5A)) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

### hdl/mbpm_ifs.sv
`timescale 1ns / 1ps

interface mbpm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [mbpm_pkg::ENTRY_W-1:0]      entry_index;
  logic [mbpm_pkg::BYTE_W-1:0]       data_byte;
  logic                              care;
  logic                              end_of_data;

  modport source (output valid, command, entry_index, data_byte, care, end_of_data,
                  input ready);
  modport sink (input valid, command, entry_index, data_byte, care, end_of_data,
                output ready);
endinterface

interface mbpm_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink (input valid, found, output ready);
endinterface

### hdl/mbpm_cfg.sv
`timescale 1ns / 1ps

module mbpm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbpm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbpm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbpm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mbpm_pkg::cfg_t                 cfg
);

  mbpm_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        mbpm_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= pwdata[mbpm_pkg::LEN_W-1:0];
        mbpm_pkg::REG_IGNORE_CASE:    cfg_r.ignore_case    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mbpm_pkg::REG_PATTERN_LENGTH:
        prdata = {{(mbpm_pkg::PDATA_W-mbpm_pkg::LEN_W){1'b0}}, cfg_r.pattern_length};
      mbpm_pkg::REG_IGNORE_CASE:
        prdata = {{(mbpm_pkg::PDATA_W-1){1'b0}}, cfg_r.ignore_case};
      default:
        prdata = '0;
    endcase
  end

endmodule

### hdl/mbpm_front.sv
`timescale 1ns / 1ps

module mbpm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  mbpm_in_if.sink              in_ch,
  output logic                 deq_valid,
  input  logic                 deq_ready,
  output mbpm_pkg::item_t      deq_item
);

  // Two-entry queue of classified requests.
  mbpm_pkg::item_t q_r [2];
  logic [1:0]      cnt_r, cnt_nxt;
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic            push, pop;
  mbpm_pkg::item_t item_in;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign deq_valid   = (cnt_r != 2'd0);
  assign pop         = deq_valid && deq_ready;
  assign deq_item    = q_r[rp_r];

  // The end mark only means something on a haystack byte.
  always_comb begin
    item_in.is_byte = (in_ch.command == mbpm_pkg::CMD_BYTE);
    item_in.entry   = in_ch.entry_index;
    item_in.data    = in_ch.data_byte;
    item_in.care    = in_ch.care;
    item_in.last    = (in_ch.command == mbpm_pkg::CMD_BYTE) && in_ch.end_of_data;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item_in;
    end
  end

endmodule

### hdl/mbpm_back.sv
`timescale 1ns / 1ps

module mbpm_back #(
  parameter int MAX_PATTERN = mbpm_pkg::MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mbpm_pkg::cfg_t   cfg,
  input  logic             deq_valid,
  output logic             deq_ready,
  input  mbpm_pkg::item_t  deq_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found
);

  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int NGRP = (MAX_PATTERN + mbpm_pkg::GRP_W - 1) / mbpm_pkg::GRP_W;
  localparam int MMW  = NGRP * mbpm_pkg::GRP_W;

  logic [mbpm_pkg::BYTE_W-1:0] pat_r   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]      care_r;
  logic [mbpm_pkg::BYTE_W-1:0] win_r   [MAX_PATTERN];
  logic [mbpm_pkg::BYTE_W-1:0] win_nxt [MAX_PATTERN];

  logic [LW-1:0]   len;
  logic [LW-1:0]   bs_r, bs_inc;
  logic            check;
  logic [MMW-1:0]  mm;
  logic            advance, pop, load_wr, byte_go;

  logic            s1_valid_r, s1_check_r, s1_last_r;
  logic [MMW-1:0]  s1_mm_r;
  logic            s2_valid_r, s2_check_r, s2_last_r;
  logic [NGRP-1:0] s2_grp_r, grp;
  logic            hit;
  logic            found_acc_r;
  logic            out_valid_r, out_found_r;

  // The whole back end moves when the result register is free or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign deq_ready = advance;
  assign pop       = deq_valid && advance;
  assign load_wr   = pop && !deq_item.is_byte;
  assign byte_go   = pop && deq_item.is_byte;

  assign len = (32'(cfg.pattern_length) > MAX_PATTERN) ? LW'(MAX_PATTERN)
                                                       : LW'(cfg.pattern_length);

  assign bs_inc = (32'(bs_r) < MAX_PATTERN) ? bs_r + LW'(1) : bs_r;
  assign check  = (len != '0) && (bs_inc >= len);

  // Window slot j always holds the byte that lines up with pattern byte j:
  // new bytes enter at slot len-1 and walk toward slot 0.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
    if (j == MAX_PATTERN - 1) begin : g_top
      assign win_nxt[j] = deq_item.data;
    end else begin : g_mid
      assign win_nxt[j] = (32'(len) == j + 1) ? deq_item.data : win_r[j+1];
    end

    assign mm[j] = (32'(len) > j) && care_r[j] &&
                   (mbpm_pkg::fold_byte(win_nxt[j], cfg.ignore_case) !=
                    mbpm_pkg::fold_byte(pat_r[j], cfg.ignore_case));

    always_ff @(posedge clk) begin
      if (load_wr && (32'(deq_item.entry) == j)) begin
        pat_r[j]  <= deq_item.data;
        care_r[j] <= deq_item.care;
      end
    end

    always_ff @(posedge clk) begin
      if (byte_go) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

  for (genvar k = MAX_PATTERN; k < MMW; k++) begin : g_pad
    assign mm[k] = 1'b0;
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp[g] = |s1_mm_r[g*mbpm_pkg::GRP_W +: mbpm_pkg::GRP_W];
    end
  end

  assign hit = s2_check_r && !(|s2_grp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      found_acc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (byte_go) begin
        bs_r <= deq_item.last ? '0 : bs_inc;
      end
      if (advance) begin
        s1_valid_r  <= byte_go;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r && s2_last_r;
        if (s2_valid_r) begin
          found_acc_r <= s2_last_r ? 1'b0 : (found_acc_r || hit);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (byte_go) begin
        s1_mm_r    <= mm;
        s1_check_r <= check;
        s1_last_r  <= deq_item.last;
      end
      s2_grp_r   <= grp;
      s2_check_r <= s1_check_r;
      s2_last_r  <= s1_last_r;
      if (s2_valid_r && s2_last_r) begin
        out_found_r <= (cfg.pattern_length == '0) || found_acc_r || hit;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

### hdl/masked_byte_pattern_matcher_top.sv
`timescale 1ns / 1ps

// A result appears on out_ch after the final haystack byte passes the s1, s2 and result registers.
// Throughput: one request per cycle, load or haystack byte, while results are taken.
// The rate is set by the window shift and parallel byte compare done as each byte is accepted.
// Reset (rst_n, synchronous, active low) clears both registers, the queue, the
// haystack byte count and the match flag; the pattern table is undefined until loaded.
module masked_byte_pattern_matcher_top #(
  parameter int MAX_PATTERN = mbpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbpm_in_if.sink                       in_ch,
  mbpm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbpm_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbpm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // The configuration registers hold the pattern length and the case folding
  // switch. They are to be written only while the block is idle; the block does not enforce this.
  mbpm_pkg::cfg_t  cfg;

  // The front accepts each request, classifies it as a table load or a
  // haystack byte, and parks it in a two-entry queue. This keeps in_ch.ready
  // independent of the result side during a stall until both queue entries are full.
  logic            deq_valid;
  logic            deq_ready;
  mbpm_pkg::item_t deq_item;

  mbpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item)
  );

  // The back applies loads in order with haystack bytes, so each byte is
  // compared against the table as it stands at that point in the stream.
  // A byte shifts into the window and every pattern position is compared in
  // the same cycle; the mismatch bits are then reduced over two registered
  // stages and folded into the per-haystack match flag. The final byte of a
  // haystack loads the result register and clears the haystack state.
  mbpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_found (out_ch.found)
  );

endmodule
